/* rtl/oal_pkg.sv */
// shared types, constants and request codes for the ordered array list
`default_nettype none
package oal_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = 6;
   localparam int CNT_W    = 7;
   localparam int WORD_W   = 32;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_FIND   = 2'd2;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [CNT_W-1:0]         position;
      logic signed [WORD_W-1:0] new_id;
      logic [WORD_W-1:0]        new_grade;
      logic signed [WORD_W-1:0] key_id;
   } req_data_type;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] found_index;
      logic [CNT_W-1:0]  entry_total;
   } rsp_data_type;

   typedef struct packed {
      logic [WORD_W-1:0] id;
      logic [WORD_W-1:0] grade;
   } record_type;

   typedef struct packed {
      logic              start;
      logic [1:0]        op;
      logic [CNT_W-1:0]  ptr;
      logic [CNT_W-1:0]  reads;
      logic [ADDR_W-1:0] pos;
      logic [WORD_W-1:0] key;
      record_type        rec;
   } walk_cmd_type;

   typedef struct packed {
      logic              done;
      logic              found;
      logic [ADDR_W-1:0] index;
   } walk_sts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_POST
   } state_type;

endpackage
`default_nettype wire

/* rtl/oal_walker.sv */
// record memory with the sequenced walk that shifts entries or searches an id
`default_nettype none
module oal_walker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire oal_pkg::walk_cmd_type cmd,
   output oal_pkg::walk_sts_type      sts
);

   oal_pkg::record_type              record_mem_ff [oal_pkg::CAPACITY];
   oal_pkg::record_type              rd_data_ff;
   logic [oal_pkg::ADDR_W-1:0]       rd_addr_ff, rd_addr_in;
   logic                             busy_ff, busy_in;
   logic                             pv_ff, pv_in;
   logic [1:0]                       op_ff, op_in;
   logic [oal_pkg::CNT_W-1:0]        ptr_ff, ptr_in;
   logic [oal_pkg::CNT_W-1:0]        left_ff, left_in;
   logic [oal_pkg::ADDR_W-1:0]       pos_ff, pos_in;
   logic [oal_pkg::WORD_W-1:0]       key_ff, key_in;
   oal_pkg::record_type              rec_ff, rec_in;

   logic                             issue, hit, drain, shift_we, rec_we, we;
   logic [oal_pkg::ADDR_W-1:0]       waddr, shift_addr;
   oal_pkg::record_type              wdata;

   always_comb begin
      issue    = busy_ff && (left_ff != '0);
      hit      = busy_ff && pv_ff && (op_ff == oal_pkg::REQ_FIND)
                 && (rd_data_ff.id == key_ff);
      drain    = busy_ff && !issue && !pv_ff;
      shift_we = busy_ff && pv_ff
                 && ((op_ff == oal_pkg::REQ_INSERT) || (op_ff == oal_pkg::REQ_DELETE));
      // insert moves each entry one place up, delete one place down
      shift_addr = (op_ff == oal_pkg::REQ_INSERT) ? rd_addr_ff + 1'b1 : rd_addr_ff - 1'b1;
      // new record lands after all moves have drained
      rec_we   = drain && (op_ff == oal_pkg::REQ_INSERT);
      we       = shift_we || rec_we;
      waddr    = rec_we ? pos_ff : shift_addr;
      wdata    = rec_we ? rec_ff : rd_data_ff;

      sts.done  = hit || drain;
      sts.found = hit;
      sts.index = hit ? rd_addr_ff : '0;
   end

   always_comb begin
      busy_in    = busy_ff;
      pv_in      = pv_ff;
      op_in      = op_ff;
      ptr_in     = ptr_ff;
      left_in    = left_ff;
      pos_in     = pos_ff;
      key_in     = key_ff;
      rec_in     = rec_ff;
      rd_addr_in = rd_addr_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         pv_in   = 1'b0;
         op_in   = cmd.op;
         ptr_in  = cmd.ptr;
         left_in = cmd.reads;
         pos_in  = cmd.pos;
         key_in  = cmd.key;
         rec_in  = cmd.rec;
      end else if (busy_ff) begin
         if (hit || drain) begin
            busy_in = 1'b0;
            pv_in   = 1'b0;
            left_in = '0;
         end else begin
            pv_in = issue;
            if (issue) begin
               rd_addr_in = ptr_ff[oal_pkg::ADDR_W-1:0];
               left_in    = left_ff - 1'b1;
               ptr_in     = (op_ff == oal_pkg::REQ_INSERT) ? ptr_ff - 1'b1 : ptr_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pv_ff   <= 1'b0;
         left_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         pv_ff   <= pv_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      ptr_ff     <= ptr_in;
      pos_ff     <= pos_in;
      key_ff     <= key_in;
      rec_ff     <= rec_in;
      rd_addr_ff <= rd_addr_in;
   end

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         record_mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= record_mem_ff[ptr_ff[oal_pkg::ADDR_W-1:0]];
   end

endmodule
`default_nettype wire

/* rtl/ordered_array_list.sv */
// top level of the ordered array list: request checks, entry count and result register
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_data (req_data_type)
//  rsp      out        rsp_valid / rsp_ready  rsp_data (rsp_data_type)
//
// one request at a time; a request that moves or compares entries raises rsp_valid after
// its walk through the one-read one-write record memory (one entry moved or one id compared
// per cycle), which ends early on a find hit; refused requests and unused codes skip the
// walk and answer straight away.
// req_ready rises with rsp_valid; synchronous reset empties the list, memory is kept.
// a stalled rsp holds the finished result and keeps req_ready low until it drains.
`default_nettype none
module ordered_array_list (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire oal_pkg::req_data_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output oal_pkg::rsp_data_type      rsp_data
);

   oal_pkg::state_type          state_ff, state_in;
   logic [oal_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [1:0]                  op_ff, op_in;
   oal_pkg::rsp_data_type       res_ff, res_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   oal_pkg::rsp_data_type       rsp_data_ff, rsp_data_in;

   oal_pkg::walk_cmd_type       cmd;
   oal_pkg::walk_sts_type       sts;

   logic                        accept, ins_ok, del_ok, legal, load;

   oal_walker u_walker (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   always_comb begin
      ins_ok = (count_ff < oal_pkg::CNT_W'(oal_pkg::CAPACITY))
               && (req_data.position <= count_ff);
      del_ok = (count_ff != '0) && (req_data.position < count_ff);
      legal  = ((req_data.req_type == oal_pkg::REQ_INSERT) && ins_ok)
               || ((req_data.req_type == oal_pkg::REQ_DELETE) && del_ok)
               || (req_data.req_type == oal_pkg::REQ_FIND);
      load   = (state_ff == oal_pkg::ST_POST) && (!rsp_valid_ff || rsp_ready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         oal_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = legal ? oal_pkg::ST_WALK : oal_pkg::ST_POST;
            end
         end
         oal_pkg::ST_WALK: begin
            if (sts.done) begin
               state_in = oal_pkg::ST_POST;
            end
         end
         oal_pkg::ST_POST: begin
            if (load) begin
               state_in = oal_pkg::ST_IDLE;
            end
         end
         default: state_in = oal_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready    = (state_ff == oal_pkg::ST_IDLE);
      accept       = req_valid && req_ready;
      count_in     = count_ff;
      op_in        = op_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      cmd.start = accept && legal;
      cmd.op    = req_data.req_type;
      cmd.pos   = req_data.position[oal_pkg::ADDR_W-1:0];
      cmd.key   = req_data.key_id;
      cmd.rec   = '{id: req_data.new_id, grade: req_data.new_grade};
      unique case (req_data.req_type)
         oal_pkg::REQ_INSERT: begin
            cmd.ptr   = count_ff - 1'b1;
            cmd.reads = count_ff - req_data.position;
         end
         oal_pkg::REQ_DELETE: begin
            cmd.ptr   = req_data.position + 1'b1;
            cmd.reads = count_ff - req_data.position - 1'b1;
         end
         default: begin
            cmd.ptr   = '0;
            cmd.reads = count_ff;
         end
      endcase

      if (accept) begin
         op_in  = req_data.req_type;
         res_in = '{ok: 1'b0, found_index: '0, entry_total: count_ff};
      end

      if ((state_ff == oal_pkg::ST_WALK) && sts.done) begin
         unique case (op_ff)
            oal_pkg::REQ_INSERT: count_in = count_ff + 1'b1;
            oal_pkg::REQ_DELETE: count_in = count_ff - 1'b1;
            default:             count_in = count_ff;
         endcase
         res_in.ok          = (op_ff != oal_pkg::REQ_FIND) || sts.found;
         res_in.found_index = sts.index;
         res_in.entry_total = count_in;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oal_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// self-checking testbench for the ordered array list: directed, fill and drain, random traffic, steady stream
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT  = 1_000_000;
   localparam int         DRAIN_CYCLES = 80;
   localparam int         REPORT_MAX   = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   oal_pkg::req_data_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   oal_pkg::rsp_data_type rsp_data;

   // shadow copy of the list
   logic [oal_pkg::WORD_W-1:0] list_ids [oal_pkg::CAPACITY];
   logic [oal_pkg::WORD_W-1:0] list_grades [oal_pkg::CAPACITY];
   int unsigned                list_len = 0;

   oal_pkg::rsp_data_type pending_results[$];
   int unsigned  error_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  requests_sent = 0;
   int unsigned  requests_granted = 0;
   int unsigned  full_refusals = 0;
   bit           idle_on = 1'b1;
   int unsigned  stall_left = 0;

   ordered_array_list u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic oal_pkg::rsp_data_type predict_list_op(
      input oal_pkg::req_data_type item);
      oal_pkg::rsp_data_type res;
      int unsigned           slot;
      int unsigned           src;
      res = '0;
      case (item.req_type)
         oal_pkg::REQ_INSERT: begin
            if (list_len < oal_pkg::CAPACITY && item.position <= list_len) begin
               for (slot = list_len; slot > item.position; slot--) begin
                  src = slot - 1;
                  list_ids[slot[oal_pkg::ADDR_W-1:0]]    = list_ids[src[oal_pkg::ADDR_W-1:0]];
                  list_grades[slot[oal_pkg::ADDR_W-1:0]] =
                     list_grades[src[oal_pkg::ADDR_W-1:0]];
               end
               list_ids[item.position[oal_pkg::ADDR_W-1:0]]    = item.new_id;
               list_grades[item.position[oal_pkg::ADDR_W-1:0]] = item.new_grade;
               list_len++;
               res.ok = 1'b1;
            end else if (list_len == oal_pkg::CAPACITY) begin
               full_refusals++;
            end
         end
         oal_pkg::REQ_DELETE: begin
            if (item.position < list_len) begin
               for (slot = item.position; slot + 1 < list_len; slot++) begin
                  src = slot + 1;
                  list_ids[slot[oal_pkg::ADDR_W-1:0]]    = list_ids[src[oal_pkg::ADDR_W-1:0]];
                  list_grades[slot[oal_pkg::ADDR_W-1:0]] =
                     list_grades[src[oal_pkg::ADDR_W-1:0]];
               end
               list_len--;
               res.ok = 1'b1;
            end
         end
         oal_pkg::REQ_FIND: begin
            for (slot = 0; slot < list_len; slot++) begin
               if (list_ids[slot[oal_pkg::ADDR_W-1:0]] == item.key_id) begin
                  res.ok          = 1'b1;
                  res.found_index = slot[oal_pkg::ADDR_W-1:0];
                  break;
               end
            end
         end
         default: ;
      endcase
      res.entry_total = list_len[oal_pkg::CNT_W-1:0];
      if (res.ok) requests_granted++;
      return res;
   endfunction

   // compare each rsp transfer with the oldest expectation
   always @(posedge clock) begin
      oal_pkg::rsp_data_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
               $display("%0t: unexpected result ok=%0b idx=%0d total=%0d",
                        $realtime, rsp_data.ok, rsp_data.found_index, rsp_data.entry_total);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.ok !== want.ok || rsp_data.found_index !== want.found_index
                || rsp_data.entry_total !== want.entry_total) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display({"%0t: mismatch exp ok=%0b idx=%0d total=%0d",
                            " got ok=%0b idx=%0d total=%0d"},
                           $realtime, want.ok, want.found_index, want.entry_total,
                           rsp_data.ok, rsp_data.found_index, rsp_data.entry_total);
            end
         end
      end
   end

   // random result side back-pressure in bursts while idle_on is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_request(input oal_pkg::req_data_type item);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      pending_results.push_back(predict_list_op(item));
   endtask

   function automatic oal_pkg::req_data_type build_request(
      input logic [1:0]                 kind,
      input int unsigned                pos,
      input logic [oal_pkg::WORD_W-1:0] id,
      input logic [oal_pkg::WORD_W-1:0] grade,
      input logic [oal_pkg::WORD_W-1:0] key);
      oal_pkg::req_data_type item;
      item.req_type  = kind;
      item.position  = pos[oal_pkg::CNT_W-1:0];
      item.new_id    = id;
      item.new_grade = grade;
      item.key_id    = key;
      return item;
   endfunction

   // small pool of ids so finds hit and duplicates occur
   function automatic logic [oal_pkg::WORD_W-1:0] pick_id();
      if ($urandom_range(0, 9) < 4) return $urandom;
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   function automatic logic [oal_pkg::WORD_W-1:0] pick_key();
      int unsigned pick;
      if (list_len != 0 && $urandom_range(0, 9) < 5) begin
         pick = $urandom_range(0, list_len - 1);
         return list_ids[pick[oal_pkg::ADDR_W-1:0]];
      end
      return pick_id();
   endfunction

   function automatic oal_pkg::req_data_type make_request(input int unsigned insert_pct,
                                                          input int unsigned delete_pct);
      int unsigned  roll;
      int unsigned  pos;
      logic [1:0]   kind;
      roll = $urandom_range(0, 99);
      if (roll < 3)                            kind = REQ_UNUSED;
      else if (roll < insert_pct)              kind = oal_pkg::REQ_INSERT;
      else if (roll < insert_pct + delete_pct) kind = oal_pkg::REQ_DELETE;
      else                                     kind = oal_pkg::REQ_FIND;
      if ($urandom_range(0, 9) == 0)
         pos = $urandom_range(0, 127);
      else if (kind == oal_pkg::REQ_INSERT)
         pos = $urandom_range(0, list_len);
      else
         pos = (list_len == 0) ? 0 : $urandom_range(0, list_len - 1);
      return build_request(kind, pos, pick_id(), $urandom, pick_key());
   endfunction

   task automatic test_directed_edges();
      // empty list: miss, refused delete, insert past count, unused code
      send_request(build_request(oal_pkg::REQ_FIND,   0, 0, 0, 32'h0));
      send_request(build_request(oal_pkg::REQ_DELETE, 0, 0, 0, 0));
      send_request(build_request(oal_pkg::REQ_INSERT, 1, 32'h1, 32'h1, 0));
      send_request(build_request(REQ_UNUSED, 0, 0, 0, 0));
      // extreme ids and grades, front, end and middle inserts, a duplicate id, refused inserts, finds
      send_request(build_request(oal_pkg::REQ_INSERT, 0, 32'h8000_0000, 32'h0000_0000, 0));
      send_request(build_request(oal_pkg::REQ_INSERT, 1, 32'h7fff_ffff, 32'hffff_ffff, 0));
      send_request(build_request(oal_pkg::REQ_INSERT, 0, 32'hffff_ffff, 32'h5555_5555, 0));
      send_request(build_request(oal_pkg::REQ_INSERT, 1, 32'h0000_0000, 32'haaaa_aaaa, 0));
      send_request(build_request(oal_pkg::REQ_INSERT, 4, 32'h7fff_ffff, 32'h1234_5678, 0));
      send_request(build_request(oal_pkg::REQ_INSERT, 127, 32'h5, 32'h5, 0));
      send_request(build_request(oal_pkg::REQ_INSERT, 64, 32'h6, 32'h6, 0));
      send_request(build_request(oal_pkg::REQ_FIND, 0, 0, 0, 32'h7fff_ffff));
      send_request(build_request(oal_pkg::REQ_FIND, 0, 0, 0, 32'h8000_0000));
      send_request(build_request(oal_pkg::REQ_FIND, 0, 0, 0, 32'h0001_e240));
      // deletes: at count, far out of range, middle, front, last; then an unused code and a find
      send_request(build_request(oal_pkg::REQ_DELETE, 5, 0, 0, 0));
      send_request(build_request(oal_pkg::REQ_DELETE, 127, 0, 0, 0));
      send_request(build_request(oal_pkg::REQ_DELETE, 2, 0, 0, 0));
      send_request(build_request(oal_pkg::REQ_DELETE, 0, 0, 0, 0));
      send_request(build_request(oal_pkg::REQ_DELETE, list_len - 1, 0, 0, 0));
      send_request(build_request(REQ_UNUSED, 127, '1, '1, '1));
      send_request(build_request(oal_pkg::REQ_FIND, 0, 0, 0, 32'hffff_ffff));
   endtask

   task automatic test_fill_and_drain(input int unsigned rounds);
      repeat (rounds) begin
         while (list_len < oal_pkg::CAPACITY) begin
            send_request(build_request(oal_pkg::REQ_INSERT, $urandom_range(0, list_len),
                                       pick_id(), $urandom, 0));
            if ($urandom_range(0, 7) == 0) send_request(make_request(0, 0));
         end
         // full list refuses inserts anywhere
         repeat (3) send_request(build_request(oal_pkg::REQ_INSERT, $urandom_range(0, 127),
                                               pick_id(), $urandom, 0));
         send_request(build_request(oal_pkg::REQ_FIND, 0, 0, 0,
            list_ids[oal_pkg::ADDR_W'(oal_pkg::CAPACITY - 1)]));
         repeat (4) send_request(make_request(0, 0));
         while (list_len != 0) begin
            send_request(build_request(oal_pkg::REQ_DELETE, $urandom_range(0, list_len - 1),
                                       pick_id(), $urandom, 0));
            if ($urandom_range(0, 7) == 0) send_request(make_request(0, 0));
         end
         send_request(build_request(oal_pkg::REQ_DELETE, $urandom_range(0, 127), 0, 0, 0));
      end
   endtask

   task automatic test_random_traffic(input int unsigned count);
      int unsigned insert_pct;
      int unsigned delete_pct;
      for (int unsigned n = 0; n < count; n++) begin
         // new mix every 50 transfers: growing, shrinking or balanced
         if (n % 50 == 0) begin
            case ($urandom_range(0, 2))
               0:       begin insert_pct = 65; delete_pct = 15; end
               1:       begin insert_pct = 20; delete_pct = 60; end
               default: begin insert_pct = 40; delete_pct = 35; end
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
         end
         send_request(make_request(insert_pct, delete_pct));
      end
   endtask

   task automatic test_steady_stream(input int unsigned count);
      idle_on = 1'b0;
      repeat (count) send_request(make_request(40, 35));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_fill_and_drain(3);
      test_random_traffic(1300);
      test_steady_stream(200);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests, %0d granted, %0d inserts refused on a full list",
               requests_sent, requests_granted, full_refusals);
      $display("%0d mismatches over %0d cycles", error_count, cycle_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
